[design/satd_pkg.sv]
// Shared types, widths and the 4-point Hadamard butterfly for the SATD block cost core.
// Used by every module of the design; depends on nothing else.
package satd_pkg;

  localparam int DIM_W         = 7;   // block_width / block_height register width
  localparam int CFG_IDX_W     = 2;
  localparam int PIX_ROW_W     = 32;  // four 8-bit pixels
  localparam int COEF_W        = 11;  // row-transformed difference
  localparam int WIDE_W        = 13;  // 2-D transformed coefficient
  localparam int MAG_W         = 12;  // magnitude of a 2-D coefficient
  localparam int LANE_W        = 14;  // sum of four magnitudes in one column
  localparam int RAW_W         = 16;  // sum over one 4x4 sub-block
  localparam int PAIR_W        = 17;  // sum over a sub-block pair
  localparam int SATD_W        = 23;
  localparam int MAX_BLOCK_DIM_DEF = 64;

  localparam logic [SATD_W-1:0]    SUM_MAX       = '1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
  localparam logic [DIM_W-1:0]     DIM_RESET     = 7'd8;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [3:0]       cquad_t;
  typedef logic [WIDE_W-1:0] wide_t;
  typedef wide_t [3:0]       wquad_t;

  // Bookkeeping that travels with a finished sub-block down the pipeline.
  typedef struct packed {
    logic close_pair;  // this sub-block closes a pair (or is the unpaired last one)
    logic blk_last;    // this sub-block completes the block
  } tag_t;

  // Unnormalized 4-point Walsh-Hadamard transform; all values two's complement.
  function automatic wquad_t hadamard4(input wquad_t s);
    wide_t  p0, m0, p1, m1;
    wquad_t d;
    p0 = s[0] + s[1];
    m0 = s[0] - s[1];
    p1 = s[2] + s[3];
    m1 = s[2] - s[3];
    d[0] = p0 + p1;
    d[1] = m0 + m1;
    d[2] = p0 - p1;
    d[3] = m0 - m1;
    return d;
  endfunction

endpackage

[design/satd_col_lane.sv]
// One column lane: vertical Hadamard over four row coefficients, magnitudes, and their sum.
// Depends on satd_pkg for the coefficient types and the butterfly function.
module satd_col_lane
  import satd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  cquad_t            col,
  output logic [LANE_W-1:0] sum_r
);

  wquad_t             col_wide;
  wquad_t             coef2d;
  logic [LANE_W-1:0]  sum_nxt;
  logic [MAG_W-1:0]   mag [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      col_wide[r] = {{(WIDE_W-COEF_W){col[r][COEF_W-1]}}, col[r]};
    end
    coef2d = hadamard4(col_wide);
    for (int k = 0; k < 4; k++) begin
      mag[k] = coef2d[k][WIDE_W-1] ? MAG_W'(-coef2d[k]) : coef2d[k][MAG_W-1:0];
    end
    sum_nxt = LANE_W'(mag[0]) + LANE_W'(mag[1]) + LANE_W'(mag[2]) + LANE_W'(mag[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

[design/satd_merge.sv]
// Merge stage: adds the four lane sums, applies pair halving, accumulates the block total
// and holds it in the output register. Depends on satd_pkg.
module satd_merge
  import satd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr,
  input  logic                   in_v,
  input  tag_t                   in_tag,
  input  logic [3:0][LANE_W-1:0] lane_sum,
  input  logic                   out_stall,
  output logic                   adv,
  output logic                   out_valid,
  output logic [SATD_W-1:0]      out_satd_value
);

  logic [PAIR_W-1:0] pair_r, pair_nxt;
  logic [SATD_W-1:0] block_r, block_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SATD_W-1:0] value_r;
  logic [RAW_W-1:0]  raw;
  logic [PAIR_W-1:0] pair_sum;
  logic [SATD_W:0]   total;
  logic [SATD_W-1:0] total_sat;
  logic              fire;

  // The whole pipeline holds only when a block total would land on an occupied,
  // stalled output register.
  assign adv  = !(in_v && in_tag.blk_last && out_valid_r && out_stall);
  assign fire = adv && in_v;

  always_comb begin
    raw       = RAW_W'(lane_sum[0]) + RAW_W'(lane_sum[1])
              + RAW_W'(lane_sum[2]) + RAW_W'(lane_sum[3]);
    pair_sum  = pair_r + PAIR_W'(raw);
    total     = {1'b0, block_r} + (SATD_W+1)'(pair_sum >> 1);
    total_sat = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SATD_W-1:0];

    pair_nxt      = pair_r;
    block_nxt     = block_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (clr) begin
      pair_nxt  = '0;
      block_nxt = '0;
    end else if (fire) begin
      if (in_tag.close_pair) begin
        pair_nxt  = '0;
        block_nxt = total_sat;
      end else begin
        pair_nxt = pair_sum;
      end
      if (in_tag.blk_last) begin
        block_nxt     = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r      <= '0;
      block_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pair_r      <= pair_nxt;
      block_r     <= block_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_tag.blk_last) begin
      value_r <= total_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_satd_value = value_r;

endmodule

[design/hadamard_satd_block_cost_core.sv]
// SATD block cost core: one 4-pixel row per cycle, row transform, four column lanes, merge.
// A block's total reaches out_valid via the s1 rows, the lane sum and the merge output registers.
// Throughput: one row item per cycle; in_stall rises only while a finished total sits stalled
// on the output register and the next block's total is ready behind it.
// Reset (rst_n low, synchronous): counters, sums and valids clear; width and height return to 8.
// Depends on satd_pkg, satd_col_lane and satd_merge.
module hadamard_satd_block_cost_core
  import satd_pkg::*;
#(
  parameter int MAX_BLOCK_DIM = MAX_BLOCK_DIM_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_ROW_W-1:0] in_orig_row,
  input  logic [PIX_ROW_W-1:0] in_ref_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SATD_W-1:0]    out_satd_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int UNITS_MAX = MAX_BLOCK_DIM / 4;
  localparam int CW        = $clog2(UNITS_MAX + 1);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [1:0]       row_r, row_nxt;
  logic [CW-1:0]    sb_r, sb_nxt;
  logic [CW-1:0]    band_r, band_nxt;
  logic [CW-1:0]    per_band, bands;

  logic   adv, in_acc, cfg_wr, cfg_clr;
  logic   sb_last, band_last;
  wquad_t diff_wide, row_wide;
  cquad_t row_coef;
  cquad_t row_store_r [0:2];

  logic            s1_v_r, s1_v_nxt;
  tag_t            s1_tag_r, in_tag;
  cquad_t [3:0]    s1_rows_r;
  cquad_t [3:0]    col_in;
  logic            s2_v_r;
  tag_t            s2_tag_r;
  logic [3:0][LANE_W-1:0] lane_sum;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // Only a write to a defined register restarts the block.
  assign cfg_clr   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign in_stall  = !adv;
  assign in_acc    = in_valid && adv;

  // Sub-blocks per band and bands per block, clamped to 1..UNITS_MAX.
  always_comb begin
    if (width_r[DIM_W-1:2] == '0) begin
      per_band = CW'(1);
    end else if (width_r[DIM_W-1:2] > UNITS_MAX) begin
      per_band = CW'(UNITS_MAX);
    end else begin
      per_band = CW'(width_r[DIM_W-1:2]);
    end
    if (height_r[DIM_W-1:2] == '0) begin
      bands = CW'(1);
    end else if (height_r[DIM_W-1:2] > UNITS_MAX) begin
      bands = CW'(UNITS_MAX);
    end else begin
      bands = CW'(height_r[DIM_W-1:2]);
    end
  end

  assign sb_last   = (sb_r == per_band - CW'(1));
  assign band_last = (band_r == bands - CW'(1));

  always_comb begin
    in_tag.close_pair = sb_r[0] || sb_last;
    in_tag.blk_last   = sb_last && band_last;
  end

  // Row transform: pixel differences and the horizontal butterfly.
  always_comb begin
    logic [8:0] d;
    for (int k = 0; k < 4; k++) begin
      d = {1'b0, in_orig_row[8*k +: 8]} - {1'b0, in_ref_row[8*k +: 8]};
      diff_wide[k] = {{(WIDE_W-9){d[8]}}, d};
    end
    row_wide = hadamard4(diff_wide);
    for (int k = 0; k < 4; k++) begin
      row_coef[k] = row_wide[k][COEF_W-1:0];
    end
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    row_nxt    = row_r;
    sb_nxt     = sb_r;
    band_nxt   = band_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_WIDTH: begin
          width_nxt = cfg_data;
        end
        REG_HEIGHT: begin
          height_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
    if (cfg_clr) begin
      row_nxt  = '0;
      sb_nxt   = '0;
      band_nxt = '0;
    end else if (in_acc) begin
      row_nxt = row_r + 2'd1;
      if (row_r == 2'd3) begin
        if (sb_last) begin
          sb_nxt   = '0;
          band_nxt = band_last ? '0 : band_r + CW'(1);
        end else begin
          sb_nxt = sb_r + CW'(1);
        end
      end
    end
  end

  assign s1_v_nxt = in_acc && (row_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      row_r    <= '0;
      sb_r     <= '0;
      band_r   <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      row_r    <= row_nxt;
      sb_r     <= sb_nxt;
      band_r   <= band_nxt;
      if (adv) begin
        s1_v_r <= s1_v_nxt;
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && row_r != 2'd3) begin
      row_store_r[row_r] <= row_coef;
    end
    if (s1_v_nxt) begin
      s1_rows_r[0] <= row_store_r[0];
      s1_rows_r[1] <= row_store_r[1];
      s1_rows_r[2] <= row_store_r[2];
      s1_rows_r[3] <= row_coef;
      s1_tag_r     <= in_tag;
    end
    if (adv) begin
      s2_tag_r <= s1_tag_r;
    end
  end

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      for (int r = 0; r < 4; r++) begin
        col_in[g][r] = s1_rows_r[r][g];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    satd_col_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .col   (col_in[g]),
      .sum_r (lane_sum[g])
    );
  end

  satd_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .clr            (cfg_clr),
    .in_v           (s2_v_r),
    .in_tag         (s2_tag_r),
    .lane_sum       (lane_sum),
    .out_stall      (out_stall),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_satd_value (out_satd_value)
  );

`ifndef NO_ASSERTIONS
  // Input is held back only by a second block total colliding with a waiting one.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result waiting");

  // The fourth row of a sub-block launches it into the column lanes.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && row_r == 2'd3) |=> s1_v_r)
    else $error("completed sub-block not launched");

  // A write to the width or height register restarts the block.
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT))
      |=> (row_r == 2'd0 && sb_r == '0 && band_r == '0))
    else $error("configuration write did not clear the counters");

  // The last sub-block of a block always produces a result.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_tag_r.blk_last && !in_stall) |=> out_valid)
    else $error("block total not presented");
`endif

endmodule

[tb/tb_hadamard_satd_block_cost_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for hadamard_satd_block_cost_core: drives pixel rows and size writes,
// predicts each block's SATD total and compares it with the core's output. Depends on satd_pkg.
module tb_hadamard_satd_block_cost_core
  import satd_pkg::*;
();

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_ROWS   = 320;
  localparam int CALM_ROWS     = 150;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int PRINT_CAP     = 40;
  localparam int MAX_RAND_ROWS = 128;

  // Register indexes past the defined ones; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef enum int {PIX_NOISE, PIX_CLOSE, PIX_RAILS} pix_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_ROW_W-1:0] in_orig_row = '0;
  logic [PIX_ROW_W-1:0] in_ref_row = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SATD_W-1:0]    out_satd_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  // Predicted core state.
  logic signed [COEF_W-1:0] tile_rows [4][4];
  int unsigned              pair_sum;
  logic [SATD_W-1:0]        block_total;
  int unsigned              row_pos;
  int unsigned              tile_pos;
  int unsigned              band_pos;
  logic [DIM_W-1:0]         shape_w;
  logic [DIM_W-1:0]         shape_h;
  logic [SATD_W-1:0]        expected_totals [$];

  logic              calm = 1'b0;
  logic              hold_wanted = 1'b0;
  int                hold_count = 0;
  int                stall_left = 0;
  int                cycle_count = 0;
  int                mismatches = 0;
  int                rows_sent = 0;
  int                totals_checked = 0;
  int                shapes_used = 0;
  int                reg_writes = 0;
  int                input_held = 0;
  logic [SATD_W-1:0] want_total;

  hadamard_satd_block_cost_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_orig_row    (in_orig_row),
    .in_ref_row     (in_ref_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_satd_value (out_satd_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int unsigned dim_units(input logic [DIM_W-1:0] dim);
    int unsigned n;
    n = dim >> 2;
    if (n < 1) n = 1;
    if (n > MAX_BLOCK_DIM_DEF / 4) n = MAX_BLOCK_DIM_DEF / 4;
    return n;
  endfunction

  function automatic int unsigned block_rows(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    return dim_units(w) * dim_units(h) * 4;
  endfunction

  function automatic void butterfly(input int s0, s1, s2, s3, output int d0, d1, d2, d3);
    int p0, m0, p1, m1;
    p0 = s0 + s1;
    m0 = s0 - s1;
    p1 = s2 + s3;
    m1 = s2 - s3;
    d0 = p0 + p1;
    d1 = m0 + m1;
    d2 = p0 - p1;
    d3 = m0 - m1;
  endfunction

  function automatic int unsigned magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_block();
    pair_sum = 0;
    block_total = '0;
    row_pos = 0;
    tile_pos = 0;
    band_pos = 0;
  endfunction

  // Row transform now; column transform and pair halving once a 4x4 tile is complete.
  task automatic predict_row(input logic [PIX_ROW_W-1:0] orig, input logic [PIX_ROW_W-1:0] refr);
    int          diff [4];
    int          h0, h1, h2, h3;
    int unsigned raw, per_band, bands, total;
    per_band = dim_units(shape_w);
    bands = dim_units(shape_h);
    for (int k = 0; k < 4; k++) diff[k] = int'(orig[8*k +: 8]) - int'(refr[8*k +: 8]);
    butterfly(diff[0], diff[1], diff[2], diff[3], h0, h1, h2, h3);
    tile_rows[row_pos][0] = h0[COEF_W-1:0];
    tile_rows[row_pos][1] = h1[COEF_W-1:0];
    tile_rows[row_pos][2] = h2[COEF_W-1:0];
    tile_rows[row_pos][3] = h3[COEF_W-1:0];
    if (row_pos < 3) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    raw = 0;
    for (int c = 0; c < 4; c++) begin
      butterfly(tile_rows[0][c], tile_rows[1][c], tile_rows[2][c], tile_rows[3][c],
                h0, h1, h2, h3);
      raw += magnitude(h0) + magnitude(h1) + magnitude(h2) + magnitude(h3);
    end
    pair_sum += raw;
    // An odd tile closes its pair; so does the last tile of a band with an odd count.
    if (tile_pos[0] || tile_pos + 1 >= per_band) begin
      total = block_total + (pair_sum >> 1);
      block_total = (total > SUM_MAX) ? SUM_MAX : total[SATD_W-1:0];
      pair_sum = 0;
    end
    tile_pos++;
    if (tile_pos < per_band) return;
    tile_pos = 0;
    band_pos++;
    if (band_pos < bands) return;
    expected_totals.push_back(block_total);
    clear_block();
  endtask

  task automatic push_row(input logic [PIX_ROW_W-1:0] orig, input logic [PIX_ROW_W-1:0] refr);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_orig_row <= orig;
    in_ref_row  <= refr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_row(orig, refr);
    rows_sent++;
  endtask

  task automatic send_rows(input int unsigned count, input pix_mode_t mode);
    logic [PIX_ROW_W-1:0] orig, refr;
    for (int unsigned i = 0; i < count; i++) begin
      orig = $urandom();
      refr = $urandom();
      for (int k = 0; k < 4; k++) begin
        unique case (mode)
          PIX_CLOSE: begin
            refr[8*k +: 8] = orig[8*k +: 8] + 8'($urandom_range(0, 8)) - 8'd4;
          end
          PIX_RAILS: begin
            orig[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            refr[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
          end
          default: ;
        endcase
      end
      push_row(orig, refr);
    end
  endtask

  // Lets the pipeline drain so that a register write cannot land on a block in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      REG_WIDTH: begin
        shape_w = val;
        clear_block();
      end
      REG_HEIGHT: begin
        shape_h = val;
        clear_block();
      end
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_shape(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
    shapes_used++;
  endtask

  task automatic run_shape(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input pix_mode_t mode, input int unsigned blocks);
    set_shape(w, h);
    for (int unsigned b = 0; b < blocks; b++) send_rows(block_rows(w, h), mode);
    wait_idle();
  endtask

  // Reset shape 8x8: a zero tile, all-plus and all-minus tiles, and a tile whose
  // coefficients all share one magnitude. Then one 4x4 block.
  task automatic test_extreme_rows();
    for (int i = 0; i < 4; i++) begin
      if (i[0]) push_row('1, '1);
      else push_row('0, '0);
    end
    repeat (4) push_row('1, '0);
    repeat (4) push_row('0, '1);
    repeat (3) push_row(32'h00FF_FFFF, 32'hFF00_0000);
    push_row(32'hFF00_0000, 32'h00FF_FFFF);
    wait_idle();
    set_shape(7'd4, 7'd4);
    push_row(32'h00FF_00FF, 32'hFF00_FF00);
    push_row(32'hFF00_FF00, 32'h00FF_00FF);
    push_row(32'h00FF_00FF, 32'hFF00_FF00);
    push_row(32'h0000_FFFF, 32'hFFFF_0000);
    wait_idle();
  endtask

  // A size write in the middle of a block throws the partial block away;
  // a write to an unused index leaves the block running.
  task automatic test_restart();
    set_shape(7'd8, 7'd8);
    send_rows(7, PIX_NOISE);
    wait_idle();
    write_reg(REG_WIDTH, 7'd8);
    cfg_valid <= 1'b0;
    send_rows(block_rows(7'd8, 7'd8), PIX_NOISE);
    send_rows(6, PIX_RAILS);
    wait_idle();
    write_reg(REG_SPARE2, 7'h7F);
    write_reg(REG_SPARE3, 7'h00);
    cfg_valid <= 1'b0;
    send_rows(10, PIX_RAILS);
    wait_idle();
  endtask

  task automatic test_size_sweep();
    run_shape(7'd12, 7'd4, PIX_NOISE, 2);
    run_shape(7'd12, 7'd8, PIX_RAILS, 1);
    run_shape(7'd16, 7'd4, PIX_CLOSE, 1);
    run_shape(7'd64, 7'd4, PIX_NOISE, 1);
    run_shape(7'd4, 7'd64, PIX_RAILS, 1);
    run_shape(7'd0, 7'd0, PIX_NOISE, 3);
    run_shape(7'd20, 7'd8, PIX_NOISE, 1);
    run_shape(7'd6, 7'd13, PIX_CLOSE, 1);
    run_shape(7'd127, 7'd6, PIX_NOISE, 1);
    run_shape(7'd5, 7'd127, PIX_RAILS, 1);
  endtask

  // The receiver holds off long enough for totals to back up into the input.
  task automatic test_output_hold();
    calm = 1'b1;
    set_shape(7'd4, 7'd4);
    hold_wanted = 1'b1;
    send_rows(40, PIX_NOISE);
    wait_idle();
    hold_wanted = 1'b0;
    calm = 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] pick_width();
    unique case ($urandom_range(0, 9))
      0, 1:    return 7'd4;
      2, 3:    return 7'd8;
      4:       return 7'd12;
      5:       return 7'd16;
      6:       return 7'd24;
      7:       return 7'd32;
      8:       return 7'($urandom_range(0, 31));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_height();
    unique case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 7'd4;
      5, 6:          return 7'd8;
      7:             return 7'd12;
      8:             return 7'($urandom_range(0, 23));
      default:       return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_random_blocks();
    int unsigned sent, rows, blocks, cut;
    logic [DIM_W-1:0] w, h;
    sent = 0;
    while (sent < RANDOM_ROWS) begin
      calm = (sent + CALM_ROWS >= RANDOM_ROWS);
      w = pick_width();
      h = pick_height();
      // Large shapes fall back to a single band so the row budget is kept.
      if (block_rows(w, h) > MAX_RAND_ROWS) h = 7'd4;
      set_shape(w, h);
      rows = block_rows(w, h);
      blocks = (rows >= 48) ? 1 : 48 / rows;
      for (int unsigned b = 0; b < blocks; b++) begin
        send_rows(rows, pix_mode_t'($urandom_range(0, 2)));
        sent += rows;
      end
      // Now and then leave a block unfinished; the next size write discards it.
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, rows - 1);
        send_rows(cut, PIX_NOISE);
        sent += cut;
      end
      wait_idle();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_wanted && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_totals.size() == 0) begin
        report_mismatch($sformatf("total %0d with no finished block", out_satd_value));
      end else begin
        want_total = expected_totals.pop_front();
        totals_checked++;
        if (out_satd_value !== want_total)
          report_mismatch($sformatf("satd_value %0d, predicted %0d",
                                    out_satd_value, want_total));
      end
    end
    if (rst_n && in_valid && in_stall) input_held++;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout: run exceeded %0d cycles", LIMIT_CYCLES);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) tile_rows[r][c] = '0;
    shape_w = DIM_RESET;
    shape_h = DIM_RESET;
    clear_block();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_rows();
    test_restart();
    test_size_sweep();
    test_output_hold();
    test_random_blocks();
    wait_idle();
    $display("Summary: %0d pixel rows over %0d block shapes, %0d register writes",
             rows_sent, shapes_used, reg_writes);
    $display("Summary: %0d block totals checked, input held off for %0d cycles",
             totals_checked, input_held);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
